/* src/bfhm_pkg.sv */
// ----------------------------------------------------------------------------
// bfhm_pkg
// Field widths, codes and register reset values shared by the hole mask block.
// ----------------------------------------------------------------------------
package bfhm_pkg;

   localparam int ALPHA_BITS     = 8;
   localparam int READ_COL_BITS  = 9;
   localparam int READ_ROW_BITS  = 8;
   localparam int CLASS_BITS     = 2;
   localparam int WIDTH_BITS     = 10;
   localparam int HEIGHT_BITS    = 9;
   localparam int CSR_DATA_BITS  = 10;
   localparam int CSR_INDEX_BITS = 2;

   typedef logic [CLASS_BITS-1:0]     pixel_class_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam pixel_class_type CLASS_EXTERIOR = 2'd0;
   localparam pixel_class_type CLASS_HOLE     = 2'd1;
   localparam pixel_class_type CLASS_OPAQUE   = 2'd2;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam csr_index_type CSR_IMAGE_WIDTH     = 2'd0;
   localparam csr_index_type CSR_IMAGE_HEIGHT    = 2'd1;
   localparam csr_index_type CSR_ALPHA_THRESHOLD = 2'd2;

   localparam logic [WIDTH_BITS-1:0]  IMAGE_WIDTH_RESET     = 10'd309;
   localparam logic [HEIGHT_BITS-1:0] IMAGE_HEIGHT_RESET    = 9'd150;
   localparam logic [ALPHA_BITS-1:0]  ALPHA_THRESHOLD_RESET = 8'd128;

endpackage

/* src/bfhm_ram.sv */
// ----------------------------------------------------------------------------
// bfhm_ram
// Generic simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bfhm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/border_flood_fill_hole_mask.sv */
// ----------------------------------------------------------------------------
// border_flood_fill_hole_mask
// A load beat stores one transparency bit (alpha below the threshold) in raster
// order. The load that completes width times height pixels starts the walk,
// during which the block is not ready: each pixel marked exterior by the
// previous walk is cleared again through the old walk queue, then the border
// pixels are seeded and each pixel taken from the queue has its in-image
// neighbors visited. The walk is paced by the single multiply-add unit that
// forms the walk and read addresses and by the one read port of each map RAM.
// A read beat answers 0 for exterior transparent, 1 for an enclosed hole and 2
// for opaque or outside the image; it is accepted while an earlier answer still
// waits on the response side.
// After reset the exterior map is swept to zero, all MAX_WIDTH times MAX_HEIGHT
// entries, before the first beat is accepted.
// ----------------------------------------------------------------------------
module border_flood_fill_hole_mask #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_type,
   input  logic [bfhm_pkg::ALPHA_BITS-1:0]        req_pixel_alpha,
   input  logic [bfhm_pkg::READ_COL_BITS-1:0]     req_read_col,
   input  logic [bfhm_pkg::READ_ROW_BITS-1:0]     req_read_row,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output bfhm_pkg::pixel_class_type              rsp_pixel_class,
   input  logic                                   csr_wr_en,
   input  bfhm_pkg::csr_index_type                csr_index,
   input  logic [bfhm_pkg::CSR_DATA_BITS-1:0]     csr_wr_data
);

   localparam int SLOTS = MAX_WIDTH * MAX_HEIGHT;
   localparam int IW    = $clog2(SLOTS);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int QW    = RW + CW;
   localparam int PW    = RW + WW;

   localparam logic [4:0] ST_INIT      = 5'd0;
   localparam logic [4:0] ST_IDLE      = 5'd1;
   localparam logic [4:0] ST_LD_CHECK  = 5'd2;
   localparam logic [4:0] ST_SC_RD     = 5'd3;
   localparam logic [4:0] ST_SC_MAD    = 5'd4;
   localparam logic [4:0] ST_SC_WR     = 5'd5;
   localparam logic [4:0] ST_WALK_INIT = 5'd6;
   localparam logic [4:0] ST_SEED      = 5'd7;
   localparam logic [4:0] ST_V_MAD     = 5'd8;
   localparam logic [4:0] ST_V_MEM     = 5'd9;
   localparam logic [4:0] ST_V_CHK     = 5'd10;
   localparam logic [4:0] ST_POP       = 5'd11;
   localparam logic [4:0] ST_POP_WAIT  = 5'd12;
   localparam logic [4:0] ST_NEXT      = 5'd13;
   localparam logic [4:0] ST_RD_MAD    = 5'd14;
   localparam logic [4:0] ST_RD_MEM    = 5'd15;
   localparam logic [4:0] ST_RD_DATA   = 5'd16;
   localparam logic [4:0] ST_RD_OUT    = 5'd17;

   localparam logic [2:0] NB_LEFT  = 3'd0;
   localparam logic [2:0] NB_RIGHT = 3'd1;
   localparam logic [2:0] NB_UP    = 3'd2;
   localparam logic [2:0] NB_DOWN  = 3'd3;

   logic [4:0]                                state_ff, state_in;
   logic [bfhm_pkg::WIDTH_BITS-1:0]           image_width_ff, image_width_in;
   logic [bfhm_pkg::HEIGHT_BITS-1:0]          image_height_ff, image_height_in;
   logic [bfhm_pkg::ALPHA_BITS-1:0]           alpha_threshold_ff, alpha_threshold_in;
   logic [IW-1:0]                             load_count_ff, load_count_in;
   logic [IW:0]                               total_ff, total_in;
   logic [IW:0]                               head_ff, head_in;
   logic [IW:0]                               tail_ff, tail_in;
   logic [IW:0]                               ptr_ff, ptr_in;
   logic [WW-1:0]                             walk_w_ff, walk_w_in;
   logic [HW-1:0]                             walk_h_ff, walk_h_in;
   logic [IW-1:0]                             mad_ff, mad_in;
   logic [CW-1:0]                             cand_col_ff, cand_col_in;
   logic [RW-1:0]                             cand_row_ff, cand_row_in;
   logic [CW-1:0]                             cur_col_ff, cur_col_in;
   logic [RW-1:0]                             cur_row_ff, cur_row_in;
   logic [2:0]                                nb_ff, nb_in;
   logic [CW-1:0]                             seed_col_ff, seed_col_in;
   logic [RW-1:0]                             seed_row_ff, seed_row_in;
   logic                                      seed_side_ff, seed_side_in;
   logic                                      seed_phase_ff, seed_phase_in;
   logic                                      ret_seed_ff, ret_seed_in;
   logic [bfhm_pkg::READ_COL_BITS-1:0]        rd_col_ff, rd_col_in;
   logic [bfhm_pkg::READ_ROW_BITS-1:0]        rd_row_ff, rd_row_in;
   logic                                      in_range_ff, in_range_in;
   bfhm_pkg::pixel_class_type                 class_ff, class_in;
   bfhm_pkg::pixel_class_type                 rsp_class_ff, rsp_class_in;
   logic                                      rsp_valid_ff, rsp_valid_in;

   logic [WW-1:0]  eff_w;
   logic [HW-1:0]  eff_h;
   logic [PW-1:0]  total_prod;
   logic [RW-1:0]  mad_row;
   logic [CW-1:0]  mad_col;
   logic [WW-1:0]  mad_w;
   logic [PW-1:0]  mad_prod;
   logic [IW-1:0]  mad_next;

   logic           trans_we;
   logic [0:0]     trans_wdata;
   logic [0:0]     trans_rdata;
   logic           ext_we;
   logic [IW-1:0]  ext_waddr;
   logic [0:0]     ext_wdata;
   logic [0:0]     ext_rdata;
   logic           q_we;
   logic [IW-1:0]  q_raddr;
   logic [QW-1:0]  q_rdata;

   always_comb begin
      if (image_width_ff == '0) begin
         eff_w = WW'(1);
      end else if (image_width_ff > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         eff_h = HW'(1);
      end else if (image_height_ff > MAX_HEIGHT) begin
         eff_h = HW'(MAX_HEIGHT);
      end else begin
         eff_h = HW'(image_height_ff);
      end
   end

   assign total_prod = PW'(eff_w) * PW'(eff_h);

   always_comb begin
      unique case (state_ff)
         ST_RD_MAD: begin
            mad_row = RW'(rd_row_ff);
            mad_col = CW'(rd_col_ff);
            mad_w   = eff_w;
         end
         ST_SC_MAD: begin
            mad_row = q_rdata[QW-1:CW];
            mad_col = q_rdata[CW-1:0];
            mad_w   = walk_w_ff;
         end
         default: begin
            mad_row = cand_row_ff;
            mad_col = cand_col_ff;
            mad_w   = walk_w_ff;
         end
      endcase
   end

   assign mad_prod = PW'(mad_row) * PW'(mad_w);
   assign mad_next = IW'(mad_prod + PW'(mad_col));

   assign trans_we    = req_valid && req_ready && (req_type == bfhm_pkg::REQ_LOAD);
   assign trans_wdata = (req_pixel_alpha < alpha_threshold_ff) ? 1'b1 : 1'b0;

   always_comb begin
      state_in           = state_ff;
      image_width_in     = image_width_ff;
      image_height_in    = image_height_ff;
      alpha_threshold_in = alpha_threshold_ff;
      load_count_in      = load_count_ff;
      total_in           = (IW+1)'(total_prod);
      head_in            = head_ff;
      tail_in            = tail_ff;
      ptr_in             = ptr_ff;
      walk_w_in          = walk_w_ff;
      walk_h_in          = walk_h_ff;
      mad_in             = mad_ff;
      cand_col_in        = cand_col_ff;
      cand_row_in        = cand_row_ff;
      cur_col_in         = cur_col_ff;
      cur_row_in         = cur_row_ff;
      nb_in              = nb_ff;
      seed_col_in        = seed_col_ff;
      seed_row_in        = seed_row_ff;
      seed_side_in       = seed_side_ff;
      seed_phase_in      = seed_phase_ff;
      ret_seed_in        = ret_seed_ff;
      rd_col_in          = rd_col_ff;
      rd_row_in          = rd_row_ff;
      in_range_in        = in_range_ff;
      class_in           = class_ff;
      rsp_class_in       = rsp_class_ff;
      rsp_valid_in       = rsp_valid_ff;
      ext_we             = 1'b0;
      ext_waddr          = mad_ff;
      ext_wdata          = 1'b0;
      q_we               = 1'b0;
      q_raddr            = head_ff[IW-1:0];

      if (csr_wr_en) begin
         unique case (csr_index)
            bfhm_pkg::CSR_IMAGE_WIDTH: begin
               image_width_in = csr_wr_data;
            end
            bfhm_pkg::CSR_IMAGE_HEIGHT: begin
               image_height_in = csr_wr_data[bfhm_pkg::HEIGHT_BITS-1:0];
            end
            bfhm_pkg::CSR_ALPHA_THRESHOLD: begin
               alpha_threshold_in = csr_wr_data[bfhm_pkg::ALPHA_BITS-1:0];
            end
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_INIT: begin
            ext_we    = 1'b1;
            ext_waddr = ptr_ff[IW-1:0];
            if (ptr_ff[IW-1:0] == IW'(SLOTS - 1)) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               rd_col_in = req_read_col;
               rd_row_in = req_read_row;
               if (req_type == bfhm_pkg::REQ_READ) begin
                  state_in = ST_RD_MAD;
               end else begin
                  state_in = ST_LD_CHECK;
               end
            end
         end
         ST_LD_CHECK: begin
            if ((IW+1)'(load_count_ff) + (IW+1)'(1) >= total_ff) begin
               load_count_in = '0;
               ptr_in        = '0;
               if (tail_ff == '0) begin
                  state_in = ST_WALK_INIT;
               end else begin
                  state_in = ST_SC_RD;
               end
            end else begin
               load_count_in = load_count_ff + 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SC_RD: begin
            q_raddr  = ptr_ff[IW-1:0];
            state_in = ST_SC_MAD;
         end
         ST_SC_MAD: begin
            mad_in   = mad_next;
            state_in = ST_SC_WR;
         end
         ST_SC_WR: begin
            ext_we = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff + 1'b1 == tail_ff) begin
               state_in = ST_WALK_INIT;
            end else begin
               state_in = ST_SC_RD;
            end
         end
         ST_WALK_INIT: begin
            walk_w_in     = eff_w;
            walk_h_in     = eff_h;
            head_in       = '0;
            tail_in       = '0;
            seed_col_in   = '0;
            seed_row_in   = '0;
            seed_side_in  = 1'b0;
            seed_phase_in = 1'b0;
            state_in      = ST_SEED;
         end
         ST_SEED: begin
            ret_seed_in = 1'b1;
            if (!seed_phase_ff) begin
               cand_col_in = seed_col_ff;
               cand_row_in = seed_side_ff ? RW'(walk_h_ff - HW'(1)) : '0;
               state_in    = ST_V_MAD;
               if (!seed_side_ff) begin
                  seed_side_in = 1'b1;
               end else begin
                  seed_side_in = 1'b0;
                  if (WW'(seed_col_ff) == walk_w_ff - WW'(1)) begin
                     seed_phase_in = 1'b1;
                     seed_row_in   = RW'(1);
                  end else begin
                     seed_col_in = seed_col_ff + 1'b1;
                  end
               end
            end else if ((HW+1)'(seed_row_ff) + (HW+1)'(1) >= (HW+1)'(walk_h_ff)) begin
               state_in = ST_POP;
            end else begin
               cand_col_in = seed_side_ff ? CW'(walk_w_ff - WW'(1)) : '0;
               cand_row_in = seed_row_ff;
               state_in    = ST_V_MAD;
               if (!seed_side_ff) begin
                  seed_side_in = 1'b1;
               end else begin
                  seed_side_in = 1'b0;
                  seed_row_in  = seed_row_ff + 1'b1;
               end
            end
         end
         ST_V_MAD: begin
            mad_in   = mad_next;
            state_in = ST_V_MEM;
         end
         ST_V_MEM: begin
            state_in = ST_V_CHK;
         end
         ST_V_CHK: begin
            if (trans_rdata[0] && !ext_rdata[0]) begin
               ext_we    = 1'b1;
               ext_wdata = 1'b1;
               q_we      = 1'b1;
               tail_in   = tail_ff + 1'b1;
            end
            state_in = ret_seed_ff ? ST_SEED : ST_NEXT;
         end
         ST_POP: begin
            if (head_ff == tail_ff) begin
               state_in = ST_IDLE;
            end else begin
               head_in  = head_ff + 1'b1;
               state_in = ST_POP_WAIT;
            end
         end
         ST_POP_WAIT: begin
            cur_row_in = q_rdata[QW-1:CW];
            cur_col_in = q_rdata[CW-1:0];
            nb_in      = NB_LEFT;
            state_in   = ST_NEXT;
         end
         ST_NEXT: begin
            ret_seed_in = 1'b0;
            nb_in       = nb_ff + 1'b1;
            cand_col_in = cur_col_ff;
            cand_row_in = cur_row_ff;
            case (nb_ff)
               NB_LEFT: begin
                  if (cur_col_ff != '0) begin
                     cand_col_in = cur_col_ff - CW'(1);
                     state_in    = ST_V_MAD;
                  end
               end
               NB_RIGHT: begin
                  if ((WW+1)'(cur_col_ff) + (WW+1)'(1) < (WW+1)'(walk_w_ff)) begin
                     cand_col_in = cur_col_ff + CW'(1);
                     state_in    = ST_V_MAD;
                  end
               end
               NB_UP: begin
                  if (cur_row_ff != '0) begin
                     cand_row_in = cur_row_ff - RW'(1);
                     state_in    = ST_V_MAD;
                  end
               end
               NB_DOWN: begin
                  if ((HW+1)'(cur_row_ff) + (HW+1)'(1) < (HW+1)'(walk_h_ff)) begin
                     cand_row_in = cur_row_ff + RW'(1);
                     state_in    = ST_V_MAD;
                  end
               end
               default: begin
                  state_in = ST_POP;
               end
            endcase
         end
         ST_RD_MAD: begin
            mad_in      = mad_next;
            in_range_in = (rd_col_ff < eff_w) && (rd_row_ff < eff_h);
            state_in    = ST_RD_MEM;
         end
         ST_RD_MEM: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            if (!in_range_ff || !trans_rdata[0]) begin
               class_in = bfhm_pkg::CLASS_OPAQUE;
            end else if (ext_rdata[0]) begin
               class_in = bfhm_pkg::CLASS_EXTERIOR;
            end else begin
               class_in = bfhm_pkg::CLASS_HOLE;
            end
            state_in = ST_RD_OUT;
         end
         ST_RD_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_class_in = class_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_INIT;
         image_width_ff     <= bfhm_pkg::IMAGE_WIDTH_RESET;
         image_height_ff    <= bfhm_pkg::IMAGE_HEIGHT_RESET;
         alpha_threshold_ff <= bfhm_pkg::ALPHA_THRESHOLD_RESET;
         load_count_ff      <= '0;
         head_ff            <= '0;
         tail_ff            <= '0;
         ptr_ff             <= '0;
         nb_ff              <= '0;
         seed_side_ff       <= 1'b0;
         seed_phase_ff      <= 1'b0;
         ret_seed_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         image_width_ff     <= image_width_in;
         image_height_ff    <= image_height_in;
         alpha_threshold_ff <= alpha_threshold_in;
         load_count_ff      <= load_count_in;
         head_ff            <= head_in;
         tail_ff            <= tail_in;
         ptr_ff             <= ptr_in;
         nb_ff              <= nb_in;
         seed_side_ff       <= seed_side_in;
         seed_phase_ff      <= seed_phase_in;
         ret_seed_ff        <= ret_seed_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff     <= total_in;
      walk_w_ff    <= walk_w_in;
      walk_h_ff    <= walk_h_in;
      mad_ff       <= mad_in;
      cand_col_ff  <= cand_col_in;
      cand_row_ff  <= cand_row_in;
      cur_col_ff   <= cur_col_in;
      cur_row_ff   <= cur_row_in;
      seed_col_ff  <= seed_col_in;
      seed_row_ff  <= seed_row_in;
      rd_col_ff    <= rd_col_in;
      rd_row_ff    <= rd_row_in;
      in_range_ff  <= in_range_in;
      class_ff     <= class_in;
      rsp_class_ff <= rsp_class_in;
   end

   bfhm_ram #(
      .WIDTH (1),
      .DEPTH (SLOTS)
   ) u_trans_ram (
      .clock   (clock),
      .wr_en   (trans_we),
      .wr_addr (load_count_ff),
      .wr_data (trans_wdata),
      .rd_addr (mad_ff),
      .rd_data (trans_rdata)
   );

   bfhm_ram #(
      .WIDTH (1),
      .DEPTH (SLOTS)
   ) u_ext_ram (
      .clock   (clock),
      .wr_en   (ext_we),
      .wr_addr (ext_waddr),
      .wr_data (ext_wdata),
      .rd_addr (mad_ff),
      .rd_data (ext_rdata)
   );

   bfhm_ram #(
      .WIDTH (QW),
      .DEPTH (SLOTS)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (tail_ff[IW-1:0]),
      .wr_data ({cand_row_ff, cand_col_ff}),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_class = rsp_class_ff;

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the border flood fill hole mask. Alpha images are
// loaded in raster order and pixel classes are read back, under several
// sizes, thresholds and handshake idling patterns. A local predictor tracks
// the transparency map, the exterior map and the border-seeded walk, and
// every response beat is checked against the class it predicts.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W       = 512;
   localparam int MAX_H       = 256;
   localparam int PIXEL_SLOTS = MAX_W * MAX_H;
   localparam int HOLD_CYCLES = 2000;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int ALPHA_W     = bfhm_pkg::ALPHA_BITS;
   localparam int COL_W       = bfhm_pkg::READ_COL_BITS;
   localparam int ROW_W       = bfhm_pkg::READ_ROW_BITS;
   localparam int DATA_W      = bfhm_pkg::CSR_DATA_BITS;
   localparam int WIDTH_W     = bfhm_pkg::WIDTH_BITS;
   localparam int HEIGHT_W    = bfhm_pkg::HEIGHT_BITS;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_type = bfhm_pkg::REQ_LOAD;
   logic [ALPHA_W-1:0]          req_pixel_alpha = '0;
   logic [COL_W-1:0]            req_read_col = '0;
   logic [ROW_W-1:0]            req_read_row = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   bfhm_pkg::pixel_class_type   rsp_pixel_class;
   logic                        csr_wr_en = 1'b0;
   bfhm_pkg::csr_index_type     csr_index = bfhm_pkg::CSR_IMAGE_WIDTH;
   logic [DATA_W-1:0]           csr_wr_data = '0;

   border_flood_fill_hole_mask #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_pixel_alpha (req_pixel_alpha),
      .req_read_col    (req_read_col),
      .req_read_row    (req_read_row),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_class (rsp_pixel_class),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   bit                      transparent_px [PIXEL_SLOTS];
   bit                      exterior_px    [PIXEL_SLOTS];
   bit                      loaded_px      [PIXEL_SLOTS];
   int unsigned             walk_list      [PIXEL_SLOTS];
   int unsigned             walk_len = 0;
   int unsigned             pixels_in = 0;
   int unsigned             walk_cycles = 0;
   logic [WIDTH_W-1:0]      width_reg = bfhm_pkg::IMAGE_WIDTH_RESET;
   logic [HEIGHT_W-1:0]     height_reg = bfhm_pkg::IMAGE_HEIGHT_RESET;
   logic [ALPHA_W-1:0]      thresh_reg = bfhm_pkg::ALPHA_THRESHOLD_RESET;

   bfhm_pkg::pixel_class_type class_due [$];
   int                      fail_count = 0;
   int unsigned             beats_sent = 0;
   int                      send_idle_pct = 0;
   int                      recv_stall_pct = 0;
   int                      hold_requests = 0;
   int                      holds_served = 0;
   int                      hold_left = 0;
   int                      cycle_count = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      bfhm_pkg::pixel_class_type due_class;
      if (!reset && rsp_valid && rsp_ready) begin
         if (class_due.size() == 0) begin
            $display("%0t: response beat with nothing expected, actual %0d",
                     $time, rsp_pixel_class);
            fail_count++;
         end else begin
            due_class = class_due.pop_front();
            if (rsp_pixel_class !== due_class) begin
               $display("%0t: pixel_class mismatch, expected %0d, actual %0d",
                        $time, due_class, rsp_pixel_class);
               fail_count++;
            end
         end
      end
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic int unsigned used_width();
      int unsigned v;
      v = width_reg;
      if (v < 1) v = 1;
      if (v > MAX_W) v = MAX_W;
      return v;
   endfunction

   function automatic int unsigned used_height();
      int unsigned v;
      v = height_reg;
      if (v < 1) v = 1;
      if (v > MAX_H) v = MAX_H;
      return v;
   endfunction

   function automatic void mark_exterior(int unsigned col, int unsigned row, int unsigned w);
      int unsigned idx;
      idx = row * w + col;
      if (idx >= PIXEL_SLOTS) return;
      if (exterior_px[idx] || !transparent_px[idx]) return;
      exterior_px[idx] = 1'b1;
      walk_list[walk_len] = idx;
      walk_len++;
   endfunction

   function automatic void flood_from_border();
      int unsigned w, h, head, idx, col, row;
      w = used_width();
      h = used_height();
      walk_cycles += 3 * walk_len;
      for (int unsigned i = 0; i < walk_len; i++) exterior_px[walk_list[i]] = 1'b0;
      walk_len = 0;
      head = 0;
      for (int unsigned c = 0; c < w; c++) begin
         mark_exterior(c, 0, w);
         mark_exterior(c, h - 1, w);
         walk_cycles += 8;
      end
      for (int unsigned r = 1; r + 1 < h; r++) begin
         mark_exterior(0, r, w);
         mark_exterior(w - 1, r, w);
         walk_cycles += 8;
      end
      while (head < walk_len) begin
         idx = walk_list[head];
         col = idx % w;
         row = idx / w;
         head++;
         walk_cycles += 7;
         if (col > 0) begin
            mark_exterior(col - 1, row, w);
            walk_cycles += 3;
         end
         if (col + 1 < w) begin
            mark_exterior(col + 1, row, w);
            walk_cycles += 3;
         end
         if (row > 0) begin
            mark_exterior(col, row - 1, w);
            walk_cycles += 3;
         end
         if (row + 1 < h) begin
            mark_exterior(col, row + 1, w);
            walk_cycles += 3;
         end
      end
   endfunction

   function automatic void absorb_load(logic [ALPHA_W-1:0] alpha);
      int unsigned total;
      total = used_width() * used_height();
      if (pixels_in < PIXEL_SLOTS) begin
         transparent_px[pixels_in] = (alpha < thresh_reg);
         loaded_px[pixels_in] = 1'b1;
      end
      if (pixels_in + 1 >= total) begin
         flood_from_border();
         pixels_in = 0;
      end else begin
         pixels_in++;
      end
   endfunction

   function automatic bfhm_pkg::pixel_class_type classify_pixel(int unsigned col,
                                                                int unsigned row);
      int unsigned w, h, idx;
      w = used_width();
      h = used_height();
      if (col >= w || row >= h) return bfhm_pkg::CLASS_OPAQUE;
      idx = row * w + col;
      if (idx >= PIXEL_SLOTS || !transparent_px[idx]) return bfhm_pkg::CLASS_OPAQUE;
      return exterior_px[idx] ? bfhm_pkg::CLASS_EXTERIOR : bfhm_pkg::CLASS_HOLE;
   endfunction

   function automatic bit read_allowed(int unsigned col, int unsigned row);
      if (col >= used_width() || row >= used_height()) return 1'b1;
      return loaded_px[row * used_width() + col];
   endfunction

   function automatic logic [ALPHA_W-1:0] pick_alpha(bit transparent);
      if (transparent && thresh_reg != 0) return ALPHA_W'($urandom_range(thresh_reg - 1));
      if (transparent) return '0;
      return ALPHA_W'($urandom_range(255, thresh_reg));
   endfunction

   task automatic send_beat(input logic kind, input logic [ALPHA_W-1:0] alpha,
                            input logic [COL_W-1:0] col,
                            input logic [ROW_W-1:0] row);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_pixel_alpha <= alpha;
      req_read_col    <= col;
      req_read_row    <= row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (kind == bfhm_pkg::REQ_LOAD) absorb_load(alpha);
      else class_due = {class_due, classify_pixel(col, row)};
      beats_sent++;
   endtask

   task automatic load_pixel(input logic [ALPHA_W-1:0] alpha);
      send_beat(bfhm_pkg::REQ_LOAD, alpha, COL_W'($urandom_range(511)),
                ROW_W'($urandom_range(255)));
   endtask

   task automatic read_pixel(input int unsigned col, input int unsigned row);
      send_beat(bfhm_pkg::REQ_READ, ALPHA_W'($urandom_range(255)), COL_W'(col),
                ROW_W'(row));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (class_due.size() != 0) @(posedge clock);
      repeat (3 * walk_cycles + 100) @(posedge clock);
      walk_cycles = 0;
   endtask

   task automatic program_regs(input logic [DATA_W-1:0] w,
                               input logic [DATA_W-1:0] h,
                               input logic [DATA_W-1:0] t);
      csr_wr_en   <= 1'b1;
      csr_index   <= bfhm_pkg::CSR_IMAGE_WIDTH;
      csr_wr_data <= w;
      @(posedge clock);
      width_reg   = w[WIDTH_W-1:0];
      csr_index   <= bfhm_pkg::CSR_IMAGE_HEIGHT;
      csr_wr_data <= h;
      @(posedge clock);
      height_reg  = h[HEIGHT_W-1:0];
      csr_index   <= bfhm_pkg::CSR_ALPHA_THRESHOLD;
      csr_wr_data <= t;
      @(posedge clock);
      thresh_reg  = t[ALPHA_W-1:0];
      csr_wr_en   <= 1'b0;
   endtask

   task automatic test_directed_image();
      logic [ALPHA_W-1:0] alphas [9];
      alphas = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd127};
      settle();
      program_regs(3, 3, 128);
      load_pixel(alphas[0]);
      read_pixel(0, 0);
      for (int k = 1; k < 9; k++) load_pixel(alphas[k]);
      read_pixel(0, 0);
      read_pixel(1, 1);
      read_pixel(1, 0);
      read_pixel(2, 2);
      read_pixel(2, 0);
      read_pixel(511, 255);
      read_pixel(3, 0);
      read_pixel(0, 3);
   endtask

   task automatic test_size_change();
      settle();
      program_regs(4, 4, 128);
      for (int k = 0; k < 5; k++) load_pixel(ALPHA_W'($urandom_range(255)));
      settle();
      program_regs(2, 2, 128);
      load_pixel(0);
      load_pixel(0);
      load_pixel(255);
      load_pixel(0);
      load_pixel(0);
      read_pixel(0, 0);
      read_pixel(1, 0);
      read_pixel(1, 1);
   endtask

   task automatic test_extreme_sizes();
      logic [DATA_W-1:0] t;
      t = DATA_W'($urandom_range(255));
      settle();
      program_regs(0, 511, t);
      for (int k = 0; k < 256; k++) load_pixel(ALPHA_W'($urandom_range(255)));
      read_pixel(0, 255);
      read_pixel(0, 0);
      read_pixel(1, 0);
      read_pixel(0, $urandom_range(255));
      read_pixel(511, 255);
      t = DATA_W'($urandom_range(255));
      settle();
      program_regs(1023, 0, t);
      for (int k = 0; k < 12; k++) load_pixel(ALPHA_W'($urandom_range(255)));
      read_pixel($urandom_range(11), 0);
      read_pixel(200, 0);
      read_pixel(0, 1);
      read_pixel(511, 255);
      settle();
      program_regs(2, 2, t);
      load_pixel(0);
      read_pixel(0, 0);
      read_pixel(1, 1);
      read_pixel(2, 0);
   endtask

   task automatic test_backpressure();
      settle();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      program_regs(6, 5, 128);
      for (int k = 0; k < 30; k++) load_pixel(pick_alpha($urandom_range(99) < 55));
      hold_requests <= hold_requests + 1;
      for (int k = 0; k < 16; k++) read_pixel($urandom_range(5), $urandom_range(4));
      settle();
   endtask

   task automatic random_image();
      int unsigned w, h, ew, eh, t, n, c0, c1, r0, r1, col, row, j, reads;
      bit ring, transparent;
      if ($urandom_range(7) == 0) begin
         w = $urandom_range(14, 8);
         h = $urandom_range(12, 6);
      end else begin
         w = $urandom_range(8, 1);
         h = $urandom_range(8, 1);
      end
      case ($urandom_range(5))
         0: t = 0;
         1: t = 255;
         default: t = $urandom_range(255, 1);
      endcase
      settle();
      program_regs(DATA_W'((w == 1 && $urandom_range(1) == 1) ? 0 : w),
                   DATA_W'((h == 1 && $urandom_range(1) == 1) ? 0 : h), DATA_W'(t));
      ew = used_width();
      eh = used_height();
      n = ew * eh;
      ring = ($urandom_range(1) != 0);
      c0 = $urandom_range(ew - 1);
      c1 = $urandom_range(ew - 1, c0);
      r0 = $urandom_range(eh - 1);
      r1 = $urandom_range(eh - 1, r0);
      for (int unsigned k = 0; k < n; k++) begin
         col = k % ew;
         row = k / ew;
         if (ring && col >= c0 && col <= c1 && row >= r0 && row <= r1)
            transparent = !(col == c0 || col == c1 || row == r0 || row == r1);
         else
            transparent = ($urandom_range(99) < 55);
         load_pixel(pick_alpha(transparent));
         if ($urandom_range(9) == 0) begin
            j = $urandom_range(k);
            read_pixel(j % ew, j / ew);
         end
      end
      reads = $urandom_range(10, 4);
      for (int unsigned k = 0; k < reads; k++) begin
         if ($urandom_range(4) == 0) begin
            col = $urandom_range(511);
            row = $urandom_range(255);
            if (!read_allowed(col, row)) col = $urandom_range(511, ew);
         end else begin
            col = $urandom_range(ew - 1);
            row = $urandom_range(eh - 1);
         end
         read_pixel(col, row);
      end
   endtask

   task automatic test_random_images(input int idle_pct, input int stall_pct,
                                     input int unsigned beats);
      int unsigned stop;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      stop = beats_sent + beats;
      while (beats_sent < stop) random_image();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_image();
      test_size_change();
      test_extreme_sizes();
      test_backpressure();
      test_random_images(0, 0, 20);
      test_random_images(74, 0, 20);
      test_random_images(0, 74, 20);
      test_random_images(11, 11, 20);
      settle();
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
